[src/dce_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the direct 2-D convolution engine.
// No dependencies; every other file of the block imports this package.
package dce_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int IDX_W     = 11;
  localparam int ELEM_IN_W = 16;
  localparam int CONV_W    = 32;
  localparam int OUT_IDX_W = 10;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_IN_HEIGHT   = 10;
  localparam int DEF_IN_WIDTH    = 10;
  localparam int DEF_KERNEL_ROWS = 3;
  localparam int DEF_KERNEL_COLS = 3;
  localparam int DEF_MAX_DIM     = 4;
  localparam int DEF_ELEM_WIDTH  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACT_WR  = 2'd0,
    MODE_WGT_WR  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATCH   = 2'd0,
    REG_CHANNEL = 2'd1,
    REG_FILTER  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PLANE,
    ST_DIV_ROW,
    ST_BASE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic wr_act;
    logic wr_wgt;
    logic load;
    logic step_plane;
    logic step_row;
    logic base;
    logic issue;
    logic out_load;
  } dce_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic idx_ok;
    logic nc_zero;
    logic pos_ge_plane;
    logic pos_ge_row;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } dce_sts_t;

endpackage

[src/dce_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the convolution engine: valid/ready plus one item.
// Depends on dce_pkg for the field widths.
interface dce_in_if import dce_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic [IDX_W-1:0]            flat_index;
  logic signed [ELEM_IN_W-1:0] element_value;

  modport source (output valid, output mode, output flat_index, output element_value,
                  input ready);
  modport sink   (input valid, input mode, input flat_index, input element_value,
                  output ready);
endinterface

[src/dce_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the convolution engine: valid/ready plus one result.
// Depends on dce_pkg for the field widths.
interface dce_out_if import dce_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CONV_W-1:0] conv_value;
  logic [OUT_IDX_W-1:0]     output_index;

  modport source (output valid, output conv_value, output output_index, input ready);
  modport sink   (input valid, input conv_value, input output_index, output ready);
endinterface

[src/dce_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the convolution engine.
// Depends on dce_pkg; drives dce_datapath through dce_cmd_t and reads dce_sts_t.
module dce_ctrl import dce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  dce_sts_t          sts,
  output dce_cmd_t          cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_ACT_WR: cmd.wr_act = 1'b1;
            MODE_WGT_WR: cmd.wr_wgt = 1'b1;
            MODE_COMPUTE: begin
              if (sts.idx_ok) begin
                cmd.load  = 1'b1;
                state_nxt = ST_DIV_PLANE;
              end
            end
            default: ;
          endcase
        end
      end
      // Split the flat index into image and filter by repeated subtraction.
      ST_DIV_PLANE: begin
        if (sts.pos_ge_plane) begin
          cmd.step_plane = 1'b1;
        end else begin
          state_nxt = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (sts.pos_ge_row) begin
          cmd.step_row = 1'b1;
        end else begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = sts.nc_zero ? ST_DONE : ST_MAC;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/dce_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the convolution engine: count registers, both element memories,
// index decomposition, address walk, multiply-accumulate and the result register.
// Depends on dce_pkg and dce_out_if; commanded by dce_ctrl.
module dce_datapath import dce_pkg::*; #(
  parameter int IN_HEIGHT   = DEF_IN_HEIGHT,
  parameter int IN_WIDTH    = DEF_IN_WIDTH,
  parameter int KERNEL_ROWS = DEF_KERNEL_ROWS,
  parameter int KERNEL_COLS = DEF_KERNEL_COLS,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic [IDX_W-1:0]            flat_index,
  input  logic signed [ELEM_IN_W-1:0] element_value,
  input  dce_cmd_t                    cmd,
  output dce_sts_t                    sts,
  dce_out_if.source                   out_beat
);

  localparam int OUT_HEIGHT = IN_HEIGHT - KERNEL_ROWS + 1;
  localparam int OUT_WIDTH  = IN_WIDTH - KERNEL_COLS + 1;
  localparam int PLANE      = OUT_HEIGHT * OUT_WIDTH;
  localparam int IN_PLANE   = IN_HEIGHT * IN_WIDTH;
  localparam int TAPS       = KERNEL_ROWS * KERNEL_COLS;
  localparam int ACT_DEPTH  = MAX_DIM * MAX_DIM * IN_PLANE;
  localparam int WGT_DEPTH  = MAX_DIM * MAX_DIM * TAPS;
  localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int CW         = $clog2(MAX_DIM + 1);
  localparam int YW         = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
  localparam int RW         = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
  localparam int SW         = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
  localparam int PLANE_W    = $clog2(PLANE + 1);
  localparam int TOT_W      = 2 * CW + PLANE_W;
  localparam int CMP_W      = (TOT_W > IDX_W) ? TOT_W : IDX_W;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  // Activation address jumps at the end of a kernel row and of a channel.
  localparam int ROW_STEP   = IN_WIDTH - KERNEL_COLS + 1;
  localparam int CH_STEP    = IN_PLANE - (KERNEL_ROWS - 1) * IN_WIDTH - KERNEL_COLS + 1;

  // Count registers, clamped to MAX_DIM as they are written.
  logic [CW-1:0] nb_r, nc_r, nk_r;
  logic [CW-1:0] cfg_clamped;

  assign cfg_clamped = (int'(cfg_data) > MAX_DIM) ? CW'(MAX_DIM) : CW'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= CW'(1);
      nc_r <= CW'(1);
      nk_r <= CW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BATCH:   nb_r <= cfg_clamped;
        REG_CHANNEL: nc_r <= cfg_clamped;
        REG_FILTER:  nk_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Element memories.
  logic signed [ELEM_WIDTH-1:0] act_mem [ACT_DEPTH];
  logic signed [ELEM_WIDTH-1:0] wgt_mem [WGT_DEPTH];
  logic signed [ELEM_WIDTH-1:0] elem_in;
  logic signed [ELEM_WIDTH-1:0] a_q_r, w_q_r;
  logic [ACT_AW-1:0]            ai_r;
  logic [WGT_AW-1:0]            wi_r;

  assign elem_in = ELEM_WIDTH'(element_value);

  always_ff @(posedge clk) begin
    if (cmd.wr_act && (int'(flat_index) < ACT_DEPTH)) begin
      act_mem[ACT_AW'(flat_index)] <= elem_in;
    end
    if (cmd.issue) begin
      a_q_r <= act_mem[ai_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_wgt && (int'(flat_index) < WGT_DEPTH)) begin
      wgt_mem[WGT_AW'(flat_index)] <= elem_in;
    end
    if (cmd.issue) begin
      w_q_r <= wgt_mem[wi_r];
    end
  end

  // Index decomposition: pos walks down by planes, then by rows.
  logic [IDX_W-1:0]     pos_r;
  logic [CW-1:0]        k_r, n_r;
  logic [YW-1:0]        y_r;
  logic [OUT_IDX_W-1:0] oidx_r;
  logic [TOT_W-1:0]     total;

  assign total = TOT_W'(nb_r * nk_r * PLANE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= flat_index;
      k_r    <= '0;
      n_r    <= '0;
      y_r    <= '0;
      oidx_r <= OUT_IDX_W'(flat_index);
    end else if (cmd.step_plane) begin
      pos_r <= IDX_W'(pos_r - PLANE);
      if (k_r == CW'(nk_r - 1'b1)) begin
        k_r <= '0;
        n_r <= CW'(n_r + 1'b1);
      end else begin
        k_r <= CW'(k_r + 1'b1);
      end
    end else if (cmd.step_row) begin
      pos_r <= IDX_W'(pos_r - OUT_WIDTH);
      y_r   <= YW'(y_r + 1'b1);
    end
  end

  // Tap walk: weights are contiguous per filter, activations jump per row/channel.
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;
  logic [SW-1:0] s_r;
  logic          s_last, r_last;

  assign s_last = (s_r == SW'(KERNEL_COLS - 1));
  assign r_last = (r_r == RW'(KERNEL_ROWS - 1));

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      wi_r <= WGT_AW'(k_r * nc_r * TAPS);
      ai_r <= ACT_AW'(n_r * nc_r * IN_PLANE + y_r * IN_WIDTH + pos_r);
      c_r  <= '0;
      r_r  <= '0;
      s_r  <= '0;
    end else if (cmd.issue) begin
      wi_r <= WGT_AW'(wi_r + 1'b1);
      if (!s_last) begin
        s_r  <= SW'(s_r + 1'b1);
        ai_r <= ACT_AW'(ai_r + 1'b1);
      end else if (!r_last) begin
        s_r  <= '0;
        r_r  <= RW'(r_r + 1'b1);
        ai_r <= ACT_AW'(ai_r + ROW_STEP);
      end else begin
        s_r  <= '0;
        r_r  <= '0;
        c_r  <= CW'(c_r + 1'b1);
        ai_r <= ACT_AW'(ai_r + CH_STEP);
      end
    end
  end

  // Read, multiply and accumulate pipeline.
  logic                     rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CONV_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= w_q_r * a_q_r;
    end
    // The sum wraps at 32 bits; the product is sign-extended or cut to fit.
    if (cmd.base) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= CONV_W'(acc_r + CONV_W'(prod_r));
    end
  end

  // Result register; a new compute may start while it waits.
  logic                     out_valid_r;
  logic signed [CONV_W-1:0] conv_out_r;
  logic [OUT_IDX_W-1:0]     idx_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      conv_out_r <= acc_r;
      idx_out_r  <= oidx_r;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.conv_value   = conv_out_r;
  assign out_beat.output_index = idx_out_r;

  assign sts.idx_ok       = (CMP_W'(flat_index) < CMP_W'(total));
  assign sts.nc_zero      = (nc_r == '0);
  assign sts.pos_ge_plane = (int'(pos_r) >= PLANE);
  assign sts.pos_ge_row   = (int'(pos_r) >= OUT_WIDTH);
  assign sts.tap_last     = (c_r == CW'(nc_r - 1'b1)) && r_last && s_last;
  assign sts.pipe_busy    = rd_vld_r | prod_vld_r;
  assign sts.out_free     = !out_valid_r || out_beat.ready;

endmodule

[src/direct_conv2d_engine.sv]
`timescale 1ns / 1ps
// Top level of the direct 2-D convolution engine (valid padding, stride 1).
// Depends on dce_pkg, dce_in_if, dce_out_if, dce_ctrl and dce_datapath.
//
// Write beats (mode 0 activation, mode 1 weight) are taken one per cycle
// while the engine is idle and give no result; a write past the end of its
// memory is dropped. A compute beat (mode 2) names an output in NKHW order and
// returns the wrapped 32-bit sum over channels and kernel taps of weight times
// activation, with the index echoed; an index beyond the configured outputs,
// and mode 3, give no result. A compute beat occupies the engine while its
// index is split into image, filter and row by one subtraction per cycle and
// while its C*R*S multiply-accumulates run on the single multiplier, fed by
// one read per cycle from each element memory, where C*R*S counts channels
// times kernel taps. After the last multiply-accumulate the engine waits for
// the read and multiply stages to drain; with zero channels the
// multiply-accumulate and drain steps are skipped. The final step waits while
// the previous result is still unaccepted. Items are taken one at a time; a
// finished result waits in an output register while the next beats are
// accepted. Memory contents are undefined until written and need no clearing
// after reset.
module direct_conv2d_engine import dce_pkg::*; #(
  parameter int IN_HEIGHT   = DEF_IN_HEIGHT,
  parameter int IN_WIDTH    = DEF_IN_WIDTH,
  parameter int KERNEL_ROWS = DEF_KERNEL_ROWS,
  parameter int KERNEL_COLS = DEF_KERNEL_COLS,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dce_in_if.sink               in_beat,
  dce_out_if.source            out_beat,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dce_cmd_t cmd;
  dce_sts_t sts;

  dce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_mode  (in_beat.mode),
    .in_ready (in_beat.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dce_datapath #(
    .IN_HEIGHT   (IN_HEIGHT),
    .IN_WIDTH    (IN_WIDTH),
    .KERNEL_ROWS (KERNEL_ROWS),
    .KERNEL_COLS (KERNEL_COLS),
    .MAX_DIM     (MAX_DIM),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .flat_index    (in_beat.flat_index),
    .element_value (in_beat.element_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_beat      (out_beat)
  );

endmodule

[tb/sv/dce_checker.sv]
`timescale 1ns / 1ps
// Checker for the direct 2-D convolution engine: watches both channels and the
// register port, predicts each convolution result and compares it on arrival.
// Depends on dce_pkg, dce_in_if and dce_out_if.
module dce_checker import dce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dce_in_if                    in_mon,
  dce_out_if                   out_mon,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int IN_H      = DEF_IN_HEIGHT;
  localparam int IN_W      = DEF_IN_WIDTH;
  localparam int K_ROWS    = DEF_KERNEL_ROWS;
  localparam int K_COLS    = DEF_KERNEL_COLS;
  localparam int OUT_W     = IN_W - K_COLS + 1;
  localparam int PLANE     = (IN_H - K_ROWS + 1) * OUT_W;
  localparam int ACT_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM * IN_H * IN_W;
  localparam int WGT_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM * K_ROWS * K_COLS;

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic [OUT_IDX_W-1:0]     output_index;
  } conv_result_t;

  logic signed [DEF_ELEM_WIDTH-1:0] act_store [ACT_DEPTH];
  logic signed [DEF_ELEM_WIDTH-1:0] wgt_store [WGT_DEPTH];
  logic [CFG_W-1:0] batch_reg, channel_reg, filter_reg;
  conv_result_t expected_conv_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) $display("ERROR: %s", msg);
  endtask

  function automatic int unsigned sat_count(input logic [CFG_W-1:0] v);
    return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : v;
  endfunction

  // Splits the NKHW index into image, filter and position, then sums the taps.
  function automatic bit predict_conv(input logic [IDX_W-1:0] idx, output conv_result_t res);
    int unsigned nb, nc, nk, q, img, filt, row, col, wi, ai;
    int acc;
    nb = sat_count(batch_reg);
    nc = sat_count(channel_reg);
    nk = sat_count(filter_reg);
    res = '0;
    if (idx >= nb * nk * PLANE) return 1'b0;
    q    = idx / PLANE;
    filt = q % nk;
    img  = q / nk;
    row  = (idx % PLANE) / OUT_W;
    col  = (idx % PLANE) % OUT_W;
    acc  = 0;
    for (int c = 0; c < nc; c++) begin
      for (int r = 0; r < K_ROWS; r++) begin
        for (int s = 0; s < K_COLS; s++) begin
          wi = ((filt * nc + c) * K_ROWS + r) * K_COLS + s;
          ai = ((img * nc + c) * IN_H + row + r) * IN_W + col + s;
          acc += int'(wgt_store[wi]) * int'(act_store[ai]);
        end
      end
    end
    res.conv_value   = acc;
    res.output_index = idx[OUT_IDX_W-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    conv_result_t want, pred;
    if (!rst_n) begin
      batch_reg   = 1;
      channel_reg = 1;
      filter_reg  = 1;
      expected_conv_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_conv_q.size() == 0) begin
          report_mismatch($sformatf("unrequested result, index %0d value %0d",
                                    out_mon.output_index, out_mon.conv_value));
        end else begin
          want = expected_conv_q.pop_front();
          if (out_mon.conv_value !== want.conv_value)
            report_mismatch($sformatf("output %0d: conv_value %0d, expected %0d",
                                      want.output_index, out_mon.conv_value,
                                      want.conv_value));
          if (out_mon.output_index !== want.output_index)
            report_mismatch($sformatf("output_index %0d, expected %0d",
                                      out_mon.output_index, want.output_index));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BATCH:   batch_reg   = cfg_data;
          REG_CHANNEL: channel_reg = cfg_data;
          REG_FILTER:  filter_reg  = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          MODE_ACT_WR: begin
            if (in_mon.flat_index < ACT_DEPTH) act_store[in_mon.flat_index] = in_mon.element_value;
          end
          MODE_WGT_WR: begin
            if (in_mon.flat_index < WGT_DEPTH) wgt_store[in_mon.flat_index] = in_mon.element_value;
          end
          MODE_COMPUTE: begin
            if (predict_conv(in_mon.flat_index, pred)) expected_conv_q.push_back(pred);
          end
          default: ;
        endcase
      end
    end
    pending = expected_conv_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the convolution engine testbench: clock, reset, stimulus and verdict.
// Depends on dce_pkg, dce_in_if, dce_out_if, dce_checker and the engine RTL.
module tb_top;
  import dce_pkg::*;

  localparam int PLANE     = (DEF_IN_HEIGHT - DEF_KERNEL_ROWS + 1) *
                             (DEF_IN_WIDTH - DEF_KERNEL_COLS + 1);
  localparam int ACT_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM * DEF_IN_HEIGHT * DEF_IN_WIDTH;
  localparam int WGT_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM * DEF_KERNEL_ROWS * DEF_KERNEL_COLS;
  localparam int MAX_OUT   = DEF_MAX_DIM * DEF_MAX_DIM * PLANE;
  localparam int IDX_MAX   = 2 ** IDX_W - 1;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  bit                   gaps_on = 1'b1;
  int unsigned          out_total = PLANE;
  int unsigned          stall_cycles = 0;

  dce_in_if  in_ch ();
  dce_out_if out_ch ();

  direct_conv2d_engine i_dut (
    .clk,
    .rst_n,
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data
  );

  dce_checker i_checker (
    .clk,
    .rst_n,
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .fail_count,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !gaps_on || ($urandom_range(99) >= 9);
    end
  end

  // Any accepted beat or register write counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("direct_conv2d_engine: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [ELEM_IN_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '1;
      3: return '0;
      default: return ELEM_IN_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic signed [ELEM_IN_W-1:0] value);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.flat_index    <= idx;
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits for every result, then for the engine to finish a silent item.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input logic [CFG_W-1:0] nb, input logic [CFG_W-1:0] nc,
                              input logic [CFG_W-1:0] nk);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BATCH;
    cfg_data  <= nb;
    @(posedge clk);
    cfg_index <= REG_CHANNEL;
    cfg_data  <= nc;
    @(posedge clk);
    cfg_index <= REG_FILTER;
    cfg_data  <= nk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    out_total = (nb > DEF_MAX_DIM ? DEF_MAX_DIM : nb) *
                (nk > DEF_MAX_DIM ? DEF_MAX_DIM : nk) * PLANE;
  endtask

  // Mostly in-range computes over a fully written store, with rewrites and noise.
  task automatic run_random(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55 && out_total > 0)
        send_beat(MODE_COMPUTE, IDX_W'($urandom_range(out_total - 1)), ELEM_IN_W'($urandom));
      else if (pick < 65)
        send_beat(MODE_COMPUTE, IDX_W'($urandom_range(IDX_MAX, out_total)),
                  ELEM_IN_W'($urandom));
      else if (pick < 80)
        send_beat(MODE_ACT_WR, IDX_W'($urandom_range(ACT_DEPTH - 1)), rand_elem());
      else if (pick < 90)
        send_beat(MODE_WGT_WR, IDX_W'($urandom_range(WGT_DEPTH - 1)), rand_elem());
      else if (pick < 93)
        send_beat(MODE_ACT_WR, IDX_W'($urandom_range(IDX_MAX, ACT_DEPTH)), rand_elem());
      else if (pick < 96)
        send_beat(MODE_WGT_WR, IDX_W'($urandom_range(IDX_MAX, WGT_DEPTH)), rand_elem());
      else
        send_beat(MODE_UNUSED, IDX_W'($urandom), ELEM_IN_W'($urandom));
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_ACT_WR;
    in_ch.flat_index    <= '0;
    in_ch.element_value <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= REG_BATCH;
    cfg_data            <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill both stores so that no compute reads an unwritten entry. The first
    // output of image 0 and filter 0 sees extreme values so its sum wraps.
    for (int i = 0; i < ACT_DEPTH; i++)
      send_beat(MODE_ACT_WR, IDX_W'(i), (i < 4 * 100 && (i % 100) / 10 < 3 && i % 10 < 3) ?
                                        16'sh7FFF : rand_elem());
    for (int i = 0; i < WGT_DEPTH; i++)
      send_beat(MODE_WGT_WR, IDX_W'(i), (i < 36) ? 16'sh8000 : rand_elem());

    // Directed part at the reset counts, then at the largest counts.
    send_beat(MODE_ACT_WR, IDX_W'(ACT_DEPTH), 16'sh7FFF);
    send_beat(MODE_ACT_WR, IDX_W'(IDX_MAX), 16'sh8000);
    send_beat(MODE_WGT_WR, IDX_W'(WGT_DEPTH), 16'sh7FFF);
    send_beat(MODE_WGT_WR, IDX_W'(IDX_MAX), '1);
    send_beat(MODE_COMPUTE, '0, '0);
    send_beat(MODE_COMPUTE, IDX_W'(PLANE - 1), '1);
    send_beat(MODE_COMPUTE, IDX_W'(PLANE), '0);
    send_beat(MODE_COMPUTE, IDX_W'(IDX_MAX), '0);
    send_beat(MODE_UNUSED, IDX_W'(IDX_MAX), '1);
    send_beat(MODE_ACT_WR, IDX_W'(ACT_DEPTH - 1), 16'sh8000);
    send_beat(MODE_WGT_WR, IDX_W'(WGT_DEPTH - 1), 16'sh8000);
    write_counts(3'd4, 3'd4, 3'd4);
    send_beat(MODE_COMPUTE, '0, '0);
    send_beat(MODE_COMPUTE, IDX_W'(MAX_OUT - 1), '0);
    send_beat(MODE_COMPUTE, IDX_W'(MAX_OUT), '0);
    send_beat(MODE_ACT_WR, '0, '0);
    send_beat(MODE_COMPUTE, '0, '0);
    send_beat(MODE_WGT_WR, '0, 16'sh7FFF);
    send_beat(MODE_COMPUTE, '0, '0);

    run_random(50);
    write_counts(3'd0, 3'd2, 3'd3);
    run_random(20);
    write_counts(3'd2, 3'd0, 3'd3);
    run_random(40);
    write_counts(3'd3, 3'd2, 3'd0);
    run_random(20);
    write_counts(3'd7, 3'd5, 3'd6);
    run_random(50);

    gaps_on = 1'b0;
    write_counts(3'd2, 3'd3, 3'd2);
    run_random(80);
    gaps_on = 1'b1;

    // Let the engine drain completely before sending more.
    run_random(30);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    run_random(30);

    write_counts(3'd1, 3'd4, 3'd1);
    run_random(50);
    write_counts(3'd4, 3'd1, 3'd4);
    run_random(50);
    repeat (2) begin
      write_counts(CFG_W'($urandom_range(7)), CFG_W'($urandom_range(7)),
                   CFG_W'($urandom_range(7)));
      run_random(40);
    end

    settle();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("direct_conv2d_engine: match");
    end else begin
      $display("direct_conv2d_engine: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dce_pkg.sv
src/dce_in_if.sv
src/dce_out_if.sv
src/dce_ctrl.sv
src/dce_datapath.sv
src/direct_conv2d_engine.sv
tb/sv/dce_checker.sv
tb/sv/tb_top.sv
